>>> hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/sbc_pkg.sv
package sbc_pkg;

    localparam int VERTEX_SLOTS_DEF = 4096;
    localparam int COORD_BITS_DEF   = 16;

    // Fixed request field widths.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int SCREEN_W = 16;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CULL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    // Capture strobes from the controller to the cross-product datapath.
    typedef struct packed {
        logic cap_origin;
        logic cap_edge_b;
        logic cap_edge_c;
        logic cap_prod;
    } sbc_cross_ctl_t;

endpackage

>>> hdl/sbc_ram.sv
module sbc_ram #(
    parameter int DEPTH = sbc_pkg::VERTEX_SLOTS_DEF,
    parameter int WIDTH = 2 * sbc_pkg::COORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/sbc_cross.sv
module sbc_cross #(
    parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  sbc_pkg::sbc_cross_ctl_t      ctl,
    input  logic signed [COORD_BITS-1:0] x_in,
    input  logic signed [COORD_BITS-1:0] y_in,
    output logic                         facing
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic signed [COORD_BITS-1:0] x0_reg;
    logic signed [COORD_BITS-1:0] y0_reg;
    logic signed [DIFF_W-1:0]     xa_reg;
    logic signed [DIFF_W-1:0]     ya_reg;
    logic signed [DIFF_W-1:0]     xb_reg;
    logic signed [DIFF_W-1:0]     yb_reg;
    logic signed [PROD_W-1:0]     p1_reg;
    logic signed [PROD_W-1:0]     p2_reg;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;

    // Edge differences never overflow at one extra bit.
    assign dx = DIFF_W'(x_in) - DIFF_W'(x0_reg);
    assign dy = DIFF_W'(y_in) - DIFF_W'(y0_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.cap_origin)
        begin
            x0_reg <= x_in;
            y0_reg <= y_in;
        end
        if (ctl.cap_edge_b)
        begin
            xa_reg <= dx;
            ya_reg <= dy;
        end
        if (ctl.cap_edge_c)
        begin
            xb_reg <= dx;
            yb_reg <= dy;
        end
        if (ctl.cap_prod)
        begin
            p1_reg <= PROD_W'(xa_reg) * PROD_W'(yb_reg);
            p2_reg <= PROD_W'(ya_reg) * PROD_W'(xb_reg);
        end
    end

    // The cross product z = p1 - p2 is not positive exactly when p1 <= p2.
    assign facing = (p1_reg <= p2_reg);

endmodule

>>> hdl/screen_backface_cull_marker.sv
// Screen-space back-face culling with per-vertex visibility marks.
// Requests enter on start with the command and its fields; a request is taken
// at a rising edge where start is high and busy is low. Every request returns
// exactly one result: done is high for one cycle with triangle_visible and
// vertex_visible valid, and the receiver has no way to hold it off.
// Load writes a vertex position and returns its result in the cycle after
// acceptance without raising busy, so loads can stream one per cycle.
// Query reads a mark, holds busy through its query state, and answers after it.
// Cull reads its three corners one after another from the single read port of
// the vertex memory, then forms the edges and the two products; the result
// strobes after the products are compared. A visible triangle then writes
// the marks of its in-range corners through the single mark-memory write
// port, so busy stays high through the three marking steps.
// Clear sweeps the mark memory one entry per cycle with busy high, and the
// result strobes after the last entry is written. After reset the same sweep
// runs, with busy high and no result.
module screen_backface_cull_marker #(
    parameter int VERTEX_SLOTS = sbc_pkg::VERTEX_SLOTS_DEF,
    parameter int COORD_BITS   = sbc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sbc_pkg::CMD_W-1:0]           command,
    input  logic [sbc_pkg::INDEX_W-1:0]         vertex_index,
    input  logic signed [sbc_pkg::SCREEN_W-1:0] screen_x,
    input  logic signed [sbc_pkg::SCREEN_W-1:0] screen_y,
    input  logic [sbc_pkg::INDEX_W-1:0]         corner_a,
    input  logic [sbc_pkg::INDEX_W-1:0]         corner_b,
    input  logic [sbc_pkg::INDEX_W-1:0]         corner_c,
    output logic                                done,
    output logic                                triangle_visible,
    output logic                                vertex_visible
);

    localparam int ADDR_W = $clog2(VERTEX_SLOTS);
    localparam int CMP_W  = ((ADDR_W > sbc_pkg::INDEX_W) ? ADDR_W : sbc_pkg::INDEX_W) + 1;
    localparam int EXT_W  = (COORD_BITS > sbc_pkg::SCREEN_W) ? COORD_BITS : sbc_pkg::SCREEN_W;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(VERTEX_SLOTS - 1);

    // Controller states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_QRY  = 4'd1;
    localparam logic [3:0] S_CB   = 4'd2;
    localparam logic [3:0] S_CC   = 4'd3;
    localparam logic [3:0] S_CD   = 4'd4;
    localparam logic [3:0] S_CM   = 4'd5;
    localparam logic [3:0] S_CZ   = 4'd6;
    localparam logic [3:0] S_MA   = 4'd7;
    localparam logic [3:0] S_MB   = 4'd8;
    localparam logic [3:0] S_MC   = 4'd9;
    localparam logic [3:0] S_INIT = 4'd10;
    localparam logic [3:0] S_CLR  = 4'd11;

    // An index is valid only below the slot count; the request field may be
    // wider or narrower than the memory address.
    function automatic logic slot_ok(logic [sbc_pkg::INDEX_W-1:0] idx);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(idx);
        return wide < CMP_W'(VERTEX_SLOTS);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(logic [sbc_pkg::INDEX_W-1:0] idx);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(idx);
        return wide[ADDR_W-1:0];
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] ca_reg, ca_next;
    logic [ADDR_W-1:0] cb_reg, cb_next;
    logic [ADDR_W-1:0] cc_reg, cc_next;
    logic [2:0]        corner_ok_reg, corner_ok_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              q_ok_reg, q_ok_next;
    logic              done_reg, done_next;
    logic              tri_reg, tri_next;
    logic              vtx_reg, vtx_next;

    logic                     accept;
    logic                     coord_we;
    logic [ADDR_W-1:0]        coord_raddr;
    logic [2*COORD_BITS-1:0]  coord_wdata;
    logic [2*COORD_BITS-1:0]  coord_rdata;
    logic signed [EXT_W-1:0]  ext_x;
    logic signed [EXT_W-1:0]  ext_y;
    logic signed [COORD_BITS-1:0] corner_x;
    logic signed [COORD_BITS-1:0] corner_y;

    logic              mark_we;
    logic [ADDR_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic              mark_rdata;

    sbc_pkg::sbc_cross_ctl_t cross_ctl;
    logic                    facing;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Screen coordinates are sign-extended, then wrapped to the stored width.
    assign ext_x       = EXT_W'(screen_x);
    assign ext_y       = EXT_W'(screen_y);
    assign coord_wdata = {ext_x[COORD_BITS-1:0], ext_y[COORD_BITS-1:0]};

    // A corner outside the slot range reads as the origin.
    assign corner_x = rd_ok_reg ? coord_rdata[2*COORD_BITS-1:COORD_BITS] : '0;
    assign corner_y = rd_ok_reg ? coord_rdata[COORD_BITS-1:0] : '0;

    sbc_ram #(
        .DEPTH (VERTEX_SLOTS),
        .WIDTH (2 * COORD_BITS)
    ) u_coord_mem (
        .clk   (clk),
        .we    (coord_we),
        .waddr (slot_addr(vertex_index)),
        .wdata (coord_wdata),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    sbc_ram #(
        .DEPTH (VERTEX_SLOTS),
        .WIDTH (1)
    ) u_mark_mem (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (slot_addr(vertex_index)),
        .rdata (mark_rdata)
    );

    sbc_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk    (clk),
        .ctl    (cross_ctl),
        .x_in   (corner_x),
        .y_in   (corner_y),
        .facing (facing)
    );

    // The corner read port walks corner a, b, c; in idle it points at the
    // incoming corner a so that a cull request starts its read at acceptance.
    always_comb
    begin
        coord_raddr = slot_addr(corner_a);
        rd_ok_next  = slot_ok(corner_a);
        if (state_reg == S_CB)
        begin
            coord_raddr = cb_reg;
            rd_ok_next  = corner_ok_reg[1];
        end
        else if (state_reg == S_CC)
        begin
            coord_raddr = cc_reg;
            rd_ok_next  = corner_ok_reg[2];
        end
    end

    // Mark writes come from the clearing sweep or from a visible triangle.
    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = clr_cnt_reg;
        mark_wdata = 1'b0;
        unique case (state_reg) inside
            S_INIT, S_CLR:
            begin
                mark_we = 1'b1;
            end
            S_MA:
            begin
                mark_we    = corner_ok_reg[0];
                mark_waddr = ca_reg;
                mark_wdata = 1'b1;
            end
            S_MB:
            begin
                mark_we    = corner_ok_reg[1];
                mark_waddr = cb_reg;
                mark_wdata = 1'b1;
            end
            S_MC:
            begin
                mark_we    = corner_ok_reg[2];
                mark_waddr = cc_reg;
                mark_wdata = 1'b1;
            end
            default:
            begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        corner_ok_next = corner_ok_reg;
        q_ok_next      = q_ok_reg;
        done_next      = 1'b0;
        tri_next       = 1'b0;
        vtx_next       = 1'b0;
        coord_we       = 1'b0;
        cross_ctl      = '0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        sbc_pkg::CMD_LOAD:
                        begin
                            coord_we  = slot_ok(vertex_index);
                            done_next = 1'b1;
                        end
                        sbc_pkg::CMD_CULL:
                        begin
                            ca_next        = slot_addr(corner_a);
                            cb_next        = slot_addr(corner_b);
                            cc_next        = slot_addr(corner_c);
                            corner_ok_next = {slot_ok(corner_c), slot_ok(corner_b),
                                              slot_ok(corner_a)};
                            state_next     = S_CB;
                        end
                        sbc_pkg::CMD_CLEAR:
                        begin
                            state_next = S_CLR;
                        end
                        sbc_pkg::CMD_QUERY:
                        begin
                            q_ok_next  = slot_ok(vertex_index);
                            state_next = S_QRY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_QRY:
            begin
                done_next  = 1'b1;
                vtx_next   = mark_rdata && q_ok_reg;
                state_next = S_IDLE;
            end
            S_CB:
            begin
                cross_ctl.cap_origin = 1'b1;
                state_next           = S_CC;
            end
            S_CC:
            begin
                cross_ctl.cap_edge_b = 1'b1;
                state_next           = S_CD;
            end
            S_CD:
            begin
                cross_ctl.cap_edge_c = 1'b1;
                state_next           = S_CM;
            end
            S_CM:
            begin
                cross_ctl.cap_prod = 1'b1;
                state_next         = S_CZ;
            end
            S_CZ:
            begin
                done_next  = 1'b1;
                tri_next   = facing;
                state_next = facing ? S_MA : S_IDLE;
            end
            S_MA:
            begin
                state_next = S_MB;
            end
            S_MB:
            begin
                state_next = S_MC;
            end
            S_MC:
            begin
                state_next = S_IDLE;
            end
            S_INIT, S_CLR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    clr_cnt_next = '0;
                    done_next    = (state_reg == S_CLR);
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            tri_reg     <= 1'b0;
            vtx_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            tri_reg     <= tri_next;
            vtx_reg     <= vtx_next;
        end
    end

    // Request payload captures carry no reset.
    always_ff @(posedge clk)
    begin
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        cc_reg        <= cc_next;
        corner_ok_reg <= corner_ok_next;
        rd_ok_reg     <= rd_ok_next;
        q_ok_reg      <= q_ok_next;
    end

    assign done             = done_reg;
    assign triangle_visible = tri_reg;
    assign vertex_visible   = vtx_reg;

`include "assert_macros.svh"

    // Result flags are low outside the strobe, and never both high.
    `ASSERT_SAME(a_flags_quiet, clk, rst_n, !done, !triangle_visible && !vertex_visible)
    `ASSERT_SAME(a_flags_exclusive, clk, rst_n, done, !(triangle_visible && vertex_visible))
    // A cull request always holds the controller for its corner reads.
    `ASSERT_NEXT(a_cull_busy, clk, rst_n, accept && (command == sbc_pkg::CMD_CULL), busy)
    // Vertex writes happen only when a load is taken in idle.
    `ASSERT_SAME(a_load_idle, clk, rst_n, coord_we, accept && (state_reg == S_IDLE))
    // Marks are set only in the three marking steps after a visible triangle.
    `ASSERT_SAME(a_mark_set, clk, rst_n, mark_we && mark_wdata,
                 (state_reg == S_MA) || (state_reg == S_MB) || (state_reg == S_MC))

endmodule
